[rtl/core/ffa_pkg.sv]
// shared types and constants of the first-fit free-list allocator
// request and result words, opcodes, controller states and datapath commands
// no dependencies
package ffa_pkg;

	localparam int POOL_BYTES_DEF   = 65536;
	localparam int HEADER_BYTES_DEF = 16;

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_RESIZE = 2'd2,
		OP_NOP    = 2'd3
	} op_e;

	typedef struct packed {
		op_e         opcode;
		logic [15:0] user_address;
		logic [15:0] request_size;
	} req_t;

	typedef struct packed {
		logic [15:0] result_address;
		logic        copy_needed;
		logic [15:0] copy_length;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_HDR_WAIT,
		ST_WALK,
		ST_SPLIT_NEW,
		ST_SPLIT_CUR,
		ST_PREV_RD,
		ST_UNLINK,
		ST_REREAD,
		ST_MOVE,
		ST_DONE
	} state_e;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_INIT,
		DP_LOAD,
		DP_READ_H,
		DP_RELEASE,
		DP_KEEP,
		DP_GRANT_START,
		DP_WALK_STEP,
		DP_HIT,
		DP_SPLIT_NEW,
		DP_SPLIT_CUR,
		DP_READ_PREV,
		DP_UNLINK,
		DP_MOVE
	} dp_cmd_e;

	typedef struct packed {
		op_e  op;
		logic ua_zero;
		logic rs_zero;
		logic loc_ok;
		logic fits;
		logic hit;
		logic split;
		logic stop;
		logic prev_ok;
		logic head_v;
	} dp_status_t;

endpackage

[rtl/core/ffa_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module ffa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/ffa_ctrl.sv]
// controller state machine of the allocator
// sequences the datapath through decode, list walk, split, unlink, release and move
// depends on ffa_pkg
module ffa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ffa_pkg::dp_status_t status,
	output ffa_pkg::dp_cmd_e    cmd,
	output logic                busy,
	output logic                done
);

	import ffa_pkg::*;

	state_e state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = DP_NOP;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd     = DP_INIT;
				state_d = ST_IDLE;
			end
			ST_IDLE, ST_DONE: begin
				busy = 1'b0;
				done = (state_q == ST_DONE);
				if (start) begin
					cmd     = DP_LOAD;
					state_d = ST_DECODE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DECODE: begin
				state_d = ST_DONE;
				unique case (status.op)
					OP_ALLOC: begin
						if (status.head_v) begin
							cmd     = DP_GRANT_START;
							state_d = ST_WALK;
						end
					end
					OP_FREE: begin
						if (!status.ua_zero && status.loc_ok) begin
							cmd     = DP_READ_H;
							state_d = ST_HDR_WAIT;
						end
					end
					OP_RESIZE: begin
						// resize of no area behaves as allocate
						if (status.ua_zero) begin
							if (status.head_v) begin
								cmd     = DP_GRANT_START;
								state_d = ST_WALK;
							end
						end else if (status.loc_ok) begin
							cmd     = DP_READ_H;
							state_d = ST_HDR_WAIT;
						end
					end
					OP_NOP: begin
						state_d = ST_DONE;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_HDR_WAIT: begin
				state_d = ST_DONE;
				if (status.op == OP_FREE || status.rs_zero) begin
					cmd = DP_RELEASE;
				end else if (status.fits) begin
					cmd = DP_KEEP;
				end else if (status.head_v) begin
					cmd     = DP_GRANT_START;
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (status.hit) begin
					cmd = DP_HIT;
					if (status.split) begin
						state_d = ST_SPLIT_NEW;
					end else if (status.prev_ok) begin
						state_d = ST_PREV_RD;
					end else begin
						state_d = ST_UNLINK;
					end
				end else if (status.stop) begin
					state_d = ST_DONE;
				end else begin
					cmd = DP_WALK_STEP;
				end
			end
			ST_SPLIT_NEW: begin
				cmd     = DP_SPLIT_NEW;
				state_d = ST_SPLIT_CUR;
			end
			ST_SPLIT_CUR: begin
				cmd     = DP_SPLIT_CUR;
				state_d = status.prev_ok ? ST_PREV_RD : ST_UNLINK;
			end
			ST_PREV_RD: begin
				// fresh read of the predecessor so its size is current
				cmd     = DP_READ_PREV;
				state_d = ST_UNLINK;
			end
			ST_UNLINK: begin
				cmd = DP_UNLINK;
				if (status.op == OP_RESIZE && !status.ua_zero) begin
					state_d = ST_REREAD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_REREAD: begin
				cmd     = DP_READ_H;
				state_d = ST_MOVE;
			end
			ST_MOVE: begin
				cmd     = DP_MOVE;
				state_d = ST_DONE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/core/ffa_dp.sv]
// datapath of the allocator: header ram, free-list head, walk registers
// executes one command from the controller per cycle and reports status
// depends on ffa_pkg and ffa_ram
module ffa_dp #(
	parameter int POOL_BYTES   = ffa_pkg::POOL_BYTES_DEF,
	parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ffa_pkg::dp_cmd_e    cmd,
	input  ffa_pkg::req_t       request,
	output ffa_pkg::dp_status_t status,
	output ffa_pkg::rsp_t       result
);

	import ffa_pkg::*;

	// headers always start on a granule boundary
	localparam int GRAN  = (HEADER_BYTES % 8 == 0) ? 8 :
	                       (HEADER_BYTES % 4 == 0) ? 4 :
	                       (HEADER_BYTES % 2 == 0) ? 2 : 1;
	localparam int GSH   = $clog2(GRAN);
	localparam int DEPTH = (POOL_BYTES + GRAN - 1) / GRAN;
	localparam int IW    = $clog2(DEPTH);
	localparam int SW    = $clog2(POOL_BYTES);
	localparam int BW    = $clog2(POOL_BYTES + 65536 + HEADER_BYTES + 1);
	localparam int LIMIT = POOL_BYTES / HEADER_BYTES + 1;
	localparam int CW    = $clog2(LIMIT + 1);
	localparam int EW    = SW + IW + 1;

	typedef struct packed {
		logic          link;
		logic [IW-1:0] next;
		logic [SW-1:0] size;
	} hdr_t;

	op_e           op_q;
	logic [15:0]   ua_q;
	logic [15:0]   rs_q;
	logic [16:0]   need_q;
	logic [IW-1:0] cur_q;
	logic [IW-1:0] prev_q;
	logic          prev_ok_q;
	logic [CW-1:0] n_q;
	hdr_t          b_q;
	logic [IW-1:0] nb_q;
	logic [SW-1:0] old_size_q;
	logic [IW-1:0] head_q;
	logic          head_v_q;
	rsp_t          res_q;

	logic          we, re;
	logic [IW-1:0] waddr, raddr;
	hdr_t          wr;
	logic [EW-1:0] rdata;
	hdr_t          rd;

	logic [BW-1:0] h_b, cur_b, size_b, need_b, nb_b;
	logic [IW-1:0] h_idx;
	logic          loc_ok;

	ffa_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_hdr_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wr),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd     = hdr_t'(rdata);
	assign h_b    = BW'(ua_q) - BW'(HEADER_BYTES);
	assign loc_ok = (ua_q >= 16'(HEADER_BYTES)) && (h_b < BW'(POOL_BYTES));
	assign h_idx  = IW'(h_b >> GSH);
	assign cur_b  = BW'(cur_q) << GSH;
	assign size_b = BW'(rd.size);
	assign need_b = BW'(need_q);
	assign nb_b   = cur_b + BW'(HEADER_BYTES) + need_b;

	always_comb begin
		status.op      = op_q;
		status.ua_zero = (ua_q == 16'd0);
		status.rs_zero = (rs_q == 16'd0);
		status.loc_ok  = loc_ok;
		status.fits    = (size_b >= BW'(rs_q));
		status.hit     = (size_b >= need_b);
		// split only when the rest exceeds a header and its header stays in the pool
		status.split   = (size_b > need_b + BW'(HEADER_BYTES)) && (nb_b < BW'(POOL_BYTES));
		status.stop    = !rd.link || (n_q == CW'(LIMIT - 1));
		status.prev_ok = prev_ok_q;
		status.head_v  = head_v_q;
	end

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = h_idx;
		raddr = h_idx;
		wr    = '0;
		case (cmd)
			DP_INIT: begin
				we      = 1'b1;
				waddr   = '0;
				wr.size = SW'(POOL_BYTES - HEADER_BYTES);
			end
			DP_READ_H: begin
				re = 1'b1;
			end
			DP_RELEASE, DP_MOVE: begin
				we      = 1'b1;
				wr.link = head_v_q;
				wr.next = head_q;
				wr.size = rd.size;
			end
			DP_GRANT_START: begin
				re    = 1'b1;
				raddr = head_q;
			end
			DP_WALK_STEP: begin
				re    = 1'b1;
				raddr = rd.next;
			end
			DP_SPLIT_NEW: begin
				we      = 1'b1;
				waddr   = nb_q;
				wr.link = b_q.link;
				wr.next = b_q.next;
				wr.size = SW'(BW'(b_q.size) - BW'(HEADER_BYTES) - need_b);
			end
			DP_SPLIT_CUR: begin
				we      = 1'b1;
				waddr   = cur_q;
				wr.link = 1'b1;
				wr.next = nb_q;
				wr.size = SW'(need_q);
			end
			DP_READ_PREV: begin
				re    = 1'b1;
				raddr = prev_q;
			end
			DP_UNLINK: begin
				we      = prev_ok_q;
				waddr   = prev_q;
				wr.link = b_q.link;
				wr.next = b_q.next;
				wr.size = rd.size;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			head_v_q <= 1'b1;
		end else begin
			case (cmd)
				DP_INIT: begin
					head_q   <= '0;
					head_v_q <= 1'b1;
				end
				DP_RELEASE, DP_MOVE: begin
					head_q   <= h_idx;
					head_v_q <= 1'b1;
				end
				DP_UNLINK: begin
					if (!prev_ok_q) begin
						head_q   <= b_q.next;
						head_v_q <= b_q.link;
					end
				end
				default: begin
					head_q <= head_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			DP_LOAD: begin
				op_q   <= request.opcode;
				ua_q   <= request.user_address;
				rs_q   <= request.request_size;
				// round up to a multiple of 8
				need_q <= (17'(request.request_size) + 17'd7) & ~17'd7;
				res_q  <= '0;
			end
			DP_KEEP: begin
				res_q.result_address <= ua_q;
			end
			DP_GRANT_START: begin
				cur_q      <= head_q;
				prev_ok_q  <= 1'b0;
				n_q        <= '0;
				old_size_q <= rd.size;
			end
			DP_WALK_STEP: begin
				prev_q    <= cur_q;
				prev_ok_q <= 1'b1;
				cur_q     <= rd.next;
				n_q       <= n_q + CW'(1);
			end
			DP_HIT: begin
				b_q  <= rd;
				nb_q <= IW'(nb_b >> GSH);
			end
			DP_SPLIT_CUR: begin
				b_q.next <= nb_q;
				b_q.link <= 1'b1;
			end
			DP_UNLINK: begin
				res_q.result_address <= 16'(cur_b + BW'(HEADER_BYTES));
			end
			DP_MOVE: begin
				res_q.copy_needed <= 1'b1;
				res_q.copy_length <= 16'(BW'(old_size_q));
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign result = res_q;

endmodule

[rtl/core/first_fit_free_list_allocator.sv]
// top level of the first-fit free-list allocator
// joins the controller and the datapath with its header ram
// depends on ffa_pkg, ffa_ctrl, ffa_dp
//
// A request word (allocate, free or resize) is taken when start is high and
// busy is low. Its result word appears on result for exactly one cycle with
// done high and must be captured then; the receiver cannot hold it off. A new
// request may be taken in the same cycle that a result is shown. After reset
// busy stays high for one cycle while the header of the whole pool is written.
// A free, or a resize that fits or shrinks to nothing, reads the addressed
// header and ends; nop and rejected addresses end after decode. An allocate
// walks the free headers from the list head and, on a hit, may split the
// block and reread its predecessor before the unlink; a moving resize then
// rereads and releases its old header. The walk visits one header per cycle,
// set by the single read port of the header ram.
module first_fit_free_list_allocator #(
	parameter int POOL_BYTES   = ffa_pkg::POOL_BYTES_DEF,
	parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ffa_pkg::req_t request,
	output logic          done,
	output ffa_pkg::rsp_t result
);

	import ffa_pkg::*;

	dp_cmd_e    cmd;
	dp_status_t status;

	ffa_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(status),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	ffa_dp #(
		.POOL_BYTES  (POOL_BYTES),
		.HEADER_BYTES(HEADER_BYTES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.request(request),
		.status (status),
		.result (result)
	);

	// a result word lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// an accepted word passes through decode before its result is shown
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result in the cycle after accept");

	// a copy is only asked for when a new area was granted
	a_copy_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.copy_needed) |-> (result.result_address != 16'd0))
		else $error("copy requested without a new address");

	a_copy_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.copy_needed) |-> (result.copy_length == 16'd0))
		else $error("copy length set without a copy");

endmodule
